// ===== sv/i2cea_pkg.sv =====
// Shared types and codes for the I2C EEPROM access sequencer.
package i2cea_pkg;

    // Input commands.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // Bus actions requested from the byte-level bus controller.
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_TX      = 3'd2;
    localparam logic [2:0] ACT_RX_NACK = 3'd3;
    localparam logic [2:0] ACT_STOP    = 3'd4;

    // Bus status codes, shifted right by three.
    localparam logic [4:0] ST_START    = 5'd1;
    localparam logic [4:0] ST_RESTART  = 5'd2;
    localparam logic [4:0] ST_SLAW_ACK = 5'd3;
    localparam logic [4:0] ST_DATA_ACK = 5'd5;
    localparam logic [4:0] ST_SLAR_ACK = 5'd8;
    localparam logic [4:0] ST_RX_NACK  = 5'd11;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_START   = 8'b0000_0010,
        PH_SLAW    = 8'b0000_0100,
        PH_ADDR    = 8'b0000_1000,
        PH_DATA    = 8'b0001_0000,
        PH_RESTART = 8'b0010_0000,
        PH_SLAR    = 8'b0100_0000,
        PH_RX      = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] tx_byte;
        logic       finished;
        logic       success;
        logic [7:0] read_value;
    } t_result;

endpackage

// ===== sv/i2c_eeprom_access_sequencer.sv =====
// Top level of the I2C EEPROM page write and random read sequencer.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  input    | in        | i_valid / o_stall       | command, word_address, buffer_slot,
//           |           |                         | data_byte, bus_status
//  output   | out       | o_valid / i_stall       | bus_action, tx_byte, finished, success,
//           |           |                         | read_value
//  config   | in        | i_cfg_wr_en             | i_cfg_wr_data (device address)
//
// Every input beat produces exactly one output beat, in the cycle after it is accepted.
// The sequencer state and the result register update in the same edge, so a new beat
// can be taken every cycle; the only limit is the single output register, when stalled.
// The input stalls only while the output register holds a beat that is itself stalled.
// Reset is synchronous and active low; it returns the sequencer to idle, clears the
// page buffer and loads the default device address.
module i2c_eeprom_access_sequencer #(
    parameter int PAGE_BYTES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    // Input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_word_address,
    input  logic [2:0] i_buffer_slot,
    input  logic [7:0] i_data_byte,
    input  logic [4:0] i_bus_status,
    // Output channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_bus_action,
    output logic [7:0] o_tx_byte,
    output logic       o_finished,
    output logic       o_success,
    output logic [7:0] o_read_value
);

    // Width of a page buffer index and of the transmitted byte counter, which must be
    // able to hold PAGE_BYTES itself.
    localparam int IDX_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int CNT_W = $clog2(PAGE_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAGE_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Sequencer state.
    i2cea_pkg::t_phase r_phase, n_phase;
    logic              r_read_mode, n_read_mode;
    logic [7:0]        r_word_addr, n_word_addr;
    logic [CNT_W-1:0]  r_bytes_sent, n_bytes_sent;
    logic [6:0]        r_dev_addr;
    logic [7:0]        r_page_buf [PAGE_BYTES];

    // Output register.
    logic                r_out_valid;
    i2cea_pkg::t_result  r_result;
    i2cea_pkg::t_result  n_result;

    logic                accept;
    logic [7:0]          sla_w;
    logic [IDX_W-1:0]    load_idx;
    logic                load_en;
    logic [IDX_W-1:0]    send_idx;
    logic [7:0]          send_byte;

    // The input side only waits when the output register is full and blocked.
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign sla_w = {r_dev_addr, 1'b0};

    // Page buffer write position; slots past the page size are dropped.
    assign load_idx = IDX_W'(i_buffer_slot);
    assign load_en  = accept && (i_command == i2cea_pkg::CMD_LOAD)
                      && (int'(i_buffer_slot) < PAGE_BYTES);

    // The byte counter is zero in the address phase, so one read port covers both the
    // first data byte and every later one.
    assign send_idx  = r_bytes_sent[IDX_W-1:0];
    assign send_byte = r_page_buf[send_idx];

    always_comb begin
        n_phase      = r_phase;
        n_read_mode  = r_read_mode;
        n_word_addr  = r_word_addr;
        n_bytes_sent = r_bytes_sent;
        n_result     = '{bus_action: i2cea_pkg::ACT_NONE, tx_byte: 8'd0, finished: 1'b0,
                         success: 1'b0, read_value: 8'd0};

        case (i_command)
            i2cea_pkg::CMD_LOAD: begin
                // Buffer write is handled in the clocked block; result is a no-op.
            end
            i2cea_pkg::CMD_WRITE, i2cea_pkg::CMD_READ: begin
                if (r_phase == i2cea_pkg::PH_IDLE) begin
                    n_read_mode         = (i_command == i2cea_pkg::CMD_READ);
                    n_word_addr         = i_word_address;
                    n_bytes_sent        = '0;
                    n_phase             = i2cea_pkg::PH_START;
                    n_result.bus_action = i2cea_pkg::ACT_START;
                end
            end
            default: begin
                // A status beat that does not fit the phase aborts the access without a
                // stop; arms override this where it is expected, PH_SLAW polls instead.
                n_phase           = i2cea_pkg::PH_IDLE;
                n_result.finished = 1'b1;
                case (r_phase)
                    i2cea_pkg::PH_IDLE: begin
                        // Status while idle is ignored.
                        n_result.finished = 1'b0;
                    end
                    i2cea_pkg::PH_START: begin
                        if (i_bus_status == i2cea_pkg::ST_START) begin
                            n_phase             = i2cea_pkg::PH_SLAW;
                            n_result.finished   = 1'b0;
                            n_result.bus_action = i2cea_pkg::ACT_TX;
                            n_result.tx_byte    = sla_w;
                        end
                    end
                    i2cea_pkg::PH_SLAW: begin
                        n_result.finished = 1'b0;
                        if (i_bus_status == i2cea_pkg::ST_SLAW_ACK) begin
                            n_phase             = i2cea_pkg::PH_ADDR;
                            n_result.bus_action = i2cea_pkg::ACT_TX;
                            n_result.tx_byte    = r_word_addr;
                        end else begin
                            // No acknowledge from the device: poll with a new start.
                            n_phase             = i2cea_pkg::PH_START;
                            n_result.bus_action = i2cea_pkg::ACT_START;
                        end
                    end
                    i2cea_pkg::PH_ADDR: begin
                        if (i_bus_status == i2cea_pkg::ST_DATA_ACK) begin
                            n_result.finished = 1'b0;
                            if (r_read_mode) begin
                                n_phase             = i2cea_pkg::PH_RESTART;
                                n_result.bus_action = i2cea_pkg::ACT_START;
                            end else begin
                                n_phase             = i2cea_pkg::PH_DATA;
                                n_result.bus_action = i2cea_pkg::ACT_TX;
                                n_result.tx_byte    = send_byte;
                                n_bytes_sent        = CNT_ONE;
                            end
                        end
                    end
                    i2cea_pkg::PH_DATA: begin
                        if (i_bus_status == i2cea_pkg::ST_DATA_ACK) begin
                            if (r_bytes_sent < CNT_FULL) begin
                                n_phase             = i2cea_pkg::PH_DATA;
                                n_result.finished   = 1'b0;
                                n_result.bus_action = i2cea_pkg::ACT_TX;
                                n_result.tx_byte    = send_byte;
                                n_bytes_sent        = r_bytes_sent + CNT_ONE;
                            end else begin
                                n_result.bus_action = i2cea_pkg::ACT_STOP;
                                n_result.success    = 1'b1;
                            end
                        end
                    end
                    i2cea_pkg::PH_RESTART: begin
                        if (i_bus_status == i2cea_pkg::ST_RESTART) begin
                            n_phase             = i2cea_pkg::PH_SLAR;
                            n_result.finished   = 1'b0;
                            n_result.bus_action = i2cea_pkg::ACT_TX;
                            n_result.tx_byte    = {r_dev_addr, 1'b1};
                        end
                    end
                    i2cea_pkg::PH_SLAR: begin
                        if (i_bus_status == i2cea_pkg::ST_SLAR_ACK) begin
                            n_phase             = i2cea_pkg::PH_RX;
                            n_result.finished   = 1'b0;
                            n_result.bus_action = i2cea_pkg::ACT_RX_NACK;
                        end
                    end
                    i2cea_pkg::PH_RX: begin
                        if (i_bus_status == i2cea_pkg::ST_RX_NACK) begin
                            n_result.bus_action = i2cea_pkg::ACT_STOP;
                            n_result.success    = 1'b1;
                            n_result.read_value = i_data_byte;
                        end
                    end
                    default: begin
                        // Corrupted phase code: fall back to idle quietly.
                        n_result.finished = 1'b0;
                    end
                endcase
            end
        endcase
    end

    // Sequencer state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cea_pkg::PH_IDLE;
            r_read_mode  <= 1'b0;
            r_word_addr  <= 8'd0;
            r_bytes_sent <= '0;
            r_dev_addr   <= i2cea_pkg::DEV_ADDR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_dev_addr <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase      <= n_phase;
                r_read_mode  <= n_read_mode;
                r_word_addr  <= n_word_addr;
                r_bytes_sent <= n_bytes_sent;
            end
        end
    end

    // Page buffer, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_BYTES; i++) begin
                r_page_buf[i] <= 8'd0;
            end
        end else if (load_en) begin
            r_page_buf[load_idx] <= i_data_byte;
        end
    end

    // Output register: loads on every accepted beat, drains when not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_bus_action = r_result.bus_action;
    assign o_tx_byte    = r_result.tx_byte;
    assign o_finished   = r_result.finished;
    assign o_success    = r_result.success;
    assign o_read_value = r_result.read_value;

`ifndef SYNTHESIS
    // A finished access never asks for a start, a byte transfer or a receive.
    a_finish_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |->
        (o_bus_action == i2cea_pkg::ACT_STOP || o_bus_action == i2cea_pkg::ACT_NONE))
        else $error("finished beat carries a bus action other than stop or none");

    // Success is only reported together with a stop on a finished access.
    a_success_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_success) |->
        (o_finished && o_bus_action == i2cea_pkg::ACT_STOP))
        else $error("success reported without a finishing stop");

    // A finished access leaves the sequencer idle.
    a_idle_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(accept) && o_finished) |-> (r_phase == i2cea_pkg::PH_IDLE))
        else $error("sequencer not idle after a finished access");

    // Transmit data only accompanies a transmit action.
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_action != i2cea_pkg::ACT_TX) |-> (o_tx_byte == 8'd0))
        else $error("transmit byte set on a non-transmit action");
`endif

endmodule
